// File: rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg: shared types and constants of the frame encoder
// Character codes, the step codes of one request's character list and the
// job descriptor that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bfe_pkg;

   // Character codes used in a frame.
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Step codes: one bit of a job's step mask for each character kind.
   localparam int NUM_STEPS = 10;
   localparam int STEP_W    = 4;
   localparam logic [STEP_W-1:0] STEP_HASH   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ADDR   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_CMD    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_G0     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_G1     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_G2     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_G3     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_SUM_HI = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SUM_LO = 4'd8;
   localparam logic [STEP_W-1:0] STEP_CR     = 4'd9;

   typedef logic [NUM_STEPS-1:0] step_mask_type;

   // One classified request: which characters to send and what they carry.
   typedef struct packed {
      step_mask_type mask;
      logic [4:0]    address;
      logic [7:0]    command;
      logic [7:0]    byte_a;
      logic [7:0]    byte_b;
      logic [7:0]    byte_c;
   } job_type;

endpackage

// File: rtl/bfe_front.sv
// ----------------------------------------------------------------------------
// bfe_front: request classifier
// Tracks the open frame and the held payload bytes, and turns each request
// into a job that lists the characters it causes.
// ----------------------------------------------------------------------------
module bfe_front import bfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_frame_start,
   input  logic [4:0] req_address,
   input  logic [7:0] req_command,
   input  logic       req_has_data,
   input  logic [7:0] req_payload_byte,
   input  logic       req_frame_end,
   input  logic       job_full,
   output logic       job_push,
   output job_type    job_data
);

   logic       in_frame_ff, in_frame_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;

   logic       accept;
   logic       open;
   logic [1:0] count_eff, count_data;
   logic [7:0] held0_data, held1_data;
   logic       group_full, group_pad, closing;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   // Classify the request against the current frame state.
   always_comb begin
      open       = req_frame_start || in_frame_ff;
      count_eff  = req_frame_start ? 2'd0 : count_ff;
      group_full = open && req_has_data && (count_eff == 2'd2);
      held0_data = held0_ff;
      held1_data = held1_ff;
      count_data = count_eff;
      if (open && req_has_data && (count_eff != 2'd2)) begin
         if (count_eff == 2'd0) begin
            held0_data = req_payload_byte;
         end else begin
            held1_data = req_payload_byte;
         end
         count_data = count_eff + 2'd1;
      end else if (group_full) begin
         count_data = 2'd0;
      end
      closing   = open && req_frame_end;
      group_pad = closing && (count_data != 2'd0);

      job_data.address = req_address;
      job_data.command = req_command;
      if (group_full) begin
         job_data.byte_a = held0_ff;
         job_data.byte_b = held1_ff;
         job_data.byte_c = req_payload_byte;
      end else begin
         job_data.byte_a = held0_data;
         job_data.byte_b = (count_data == 2'd2) ? held1_data : 8'd0;
         job_data.byte_c = 8'd0;
      end
      job_data.mask = '0;
      job_data.mask[STEP_HASH]   = req_frame_start;
      job_data.mask[STEP_ADDR]   = req_frame_start;
      job_data.mask[STEP_CMD]    = req_frame_start;
      job_data.mask[STEP_G0]     = group_full || group_pad;
      job_data.mask[STEP_G1]     = group_full || group_pad;
      job_data.mask[STEP_G2]     = group_full || group_pad;
      job_data.mask[STEP_G3]     = group_full || group_pad;
      job_data.mask[STEP_SUM_HI] = closing;
      job_data.mask[STEP_SUM_LO] = closing;
      job_data.mask[STEP_CR]     = closing;

      in_frame_in = open && !req_frame_end;
      count_in    = closing ? 2'd0 : count_data;
      held0_in    = held0_data;
      held1_in    = held1_data;
   end

   // Requests that cause no character are dropped here.
   assign job_push = accept && (job_data.mask != '0);

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= 2'd0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   // Held bytes are qualified by the count and need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

endmodule

// File: rtl/bfe_job_queue.sv
// ----------------------------------------------------------------------------
// bfe_job_queue: two-entry job queue
// Decouples the classifier from the character sequencer.
// ----------------------------------------------------------------------------
module bfe_job_queue import bfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/bfe_back.sv
// ----------------------------------------------------------------------------
// bfe_back: character sequencer
// Walks each job's step mask one character a cycle while the result slot is
// free, keeps the running checksum and drives the result register.
// ----------------------------------------------------------------------------
module bfe_back import bfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job_data,
   output logic       job_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_frame,
   output logic       rsp_end_of_run
);

   step_mask_type     mask_ff, mask_in;
   job_type           job_ff;
   logic [11:0]       sum_ff, sum_in;
   logic [11:0]       csum_ff;
   logic              out_valid_ff;
   logic [7:0]        char_ff;
   logic              eof_ff, eor_ff;

   logic [STEP_W-1:0] step;
   step_mask_type     lowest, rest;
   logic              slot_free, emit, load;
   logic [7:0]        ch;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign emit      = (mask_ff != '0) && slot_free;
   assign lowest    = mask_ff & (~mask_ff + step_mask_type'(1));
   assign rest      = mask_ff & ~lowest;
   assign load      = !job_empty && ((mask_ff == '0) || (emit && (rest == '0)));
   assign job_pop   = load;

   // Pick the lowest pending step.
   always_comb begin
      step = STEP_HASH;
      for (int i = NUM_STEPS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            step = STEP_W'(i);
         end
      end
   end

   // Character of the current step.
   always_comb begin
      unique case (step)
         STEP_HASH:   ch = CHAR_HASH;
         STEP_ADDR:   ch = CHAR_LOWER_A + {3'b000, job_ff.address};
         STEP_CMD:    ch = job_ff.command;
         STEP_G0:     ch = CHAR_EQUAL + {2'b00, job_ff.byte_a[7:2]};
         STEP_G1:     ch = CHAR_EQUAL + {2'b00, job_ff.byte_a[1:0], job_ff.byte_b[7:4]};
         STEP_G2:     ch = CHAR_EQUAL + {2'b00, job_ff.byte_b[3:0], job_ff.byte_c[7:6]};
         STEP_G3:     ch = CHAR_EQUAL + {2'b00, job_ff.byte_c[5:0]};
         STEP_SUM_HI: ch = CHAR_EQUAL + {2'b00, sum_ff[11:6]};
         STEP_SUM_LO: ch = CHAR_EQUAL + {2'b00, csum_ff[5:0]};
         STEP_CR:     ch = CHAR_CR;
         default:     ch = CHAR_CR;
      endcase
   end

   // Next step mask and running sum; a header restarts the sum and a carriage return clears it.
   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = job_data.mask;
      end else if (emit) begin
         mask_in = rest;
      end
      sum_in = sum_ff;
      if (emit) begin
         if (step == STEP_HASH) begin
            sum_in = {4'b0000, CHAR_HASH};
         end else if (step == STEP_CR) begin
            sum_in = '0;
         end else begin
            sum_in = sum_ff + {4'b0000, ch};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         sum_ff  <= sum_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: current job, latched checksum and result.
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_data;
      end
      if (emit && (step == STEP_SUM_HI)) begin
         csum_ff <= sum_ff;
      end
      if (emit) begin
         char_ff <= ch;
         eof_ff  <= (step == STEP_CR);
         eor_ff  <= (rest == '0);
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_end_of_frame = eof_ff;
   assign rsp_end_of_run   = eor_ff;

endmodule

// File: rtl/base64_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// base64_frame_encoder_core: framed six-bit text encoder
// Turns frame requests and payload bytes into header, packed payload,
// checksum and carriage return characters.
// ----------------------------------------------------------------------------
//   Channel    Handshake            Fields
//   request    req_push / req_full  frame_start address command has_data
//                                   payload_byte frame_end
//   response   rsp_pop / rsp_empty  out_char end_of_frame end_of_run
//
// A request is taken whenever the two-entry job queue has room; it causes
// 0 to 10 characters, sent one a cycle by the sequencer while the response
// side keeps popping, so the single result port sets the sustained rate.
// A first character passes the job queue, the step mask and the result register.
// Reset is synchronous and clears the frame state, the queue and the result.
// A stalled response holds the sequencer; a full queue raises req_full.
// ----------------------------------------------------------------------------
module base64_frame_encoder_core import bfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_frame_start,
   input  logic [4:0] req_address,
   input  logic [7:0] req_command,
   input  logic       req_has_data,
   input  logic [7:0] req_payload_byte,
   input  logic       req_frame_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_frame,
   output logic       rsp_end_of_run
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in, job_out;

   // Front end: classify requests.
   bfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frame_start  (req_frame_start),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_has_data     (req_has_data),
      .req_payload_byte (req_payload_byte),
      .req_frame_end    (req_frame_end),
      .job_full         (job_full),
      .job_push         (job_push),
      .job_data         (job_in)
   );

   // Job queue between the two halves.
   bfe_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out)
   );

   // Back end: emit characters.
   bfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (job_empty),
      .job_data         (job_out),
      .job_pop          (job_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   // The closing character always ends its request's run.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_frame) |-> rsp_end_of_run)
      else $error("end of frame without end of run");

   // The closing character is a carriage return.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_frame) |-> (rsp_out_char == CHAR_CR))
      else $error("end of frame on a character other than carriage return");

   // A job is never pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_push)
      else $error("job pushed into a full queue");

endmodule

// File: tb/sv/base64_frame_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_frame_encoder_checker: character predictor and response checker
// Watches the request and response channels of the frame encoder. It keeps
// its own copy of the frame state, works out the characters that every
// accepted request should produce and compares each accepted response with
// the oldest outstanding character. It reports mismatches to the test top.
// ----------------------------------------------------------------------------
module base64_frame_encoder_checker import bfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       req_frame_start,
   input  logic [4:0] req_address,
   input  logic [7:0] req_command,
   input  logic       req_has_data,
   input  logic [7:0] req_payload_byte,
   input  logic       req_frame_end,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_end_of_frame,
   input  logic       rsp_end_of_run,
   output int         mismatch_count,
   output int         chars_outstanding
);

   // One character of the encoded frame with its two flags.
   typedef struct packed {
      logic [7:0] code;
      logic       end_of_frame;
      logic       end_of_run;
   } frame_char_type;

   frame_char_type expected_chars[$];
   frame_char_type oldest_char;

   // Shadow copy of the encoder's frame state.
   logic [7:0]  held_bytes [2];
   logic [1:0]  held_count;
   logic [11:0] char_sum;
   logic        frame_open;

   // The newest predicted character is held back one step so that the last
   // character of a request can be flagged as the end of its run.
   frame_char_type staged_char;
   bit             staged_valid;

   task automatic put_char(input logic [7:0] code, input logic last_of_frame);
      if (staged_valid) begin
         expected_chars.push_back(staged_char);
      end
      staged_char.code         = code;
      staged_char.end_of_frame = last_of_frame;
      staged_char.end_of_run   = 1'b0;
      staged_valid             = 1'b1;
      char_sum                 = char_sum + {4'b0000, code};
   endtask

   // Three bytes become four characters, six bits each, high bits first.
   task automatic put_group(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c);
      put_char(CHAR_EQUAL + {2'b00, a[7:2]}, 1'b0);
      put_char(CHAR_EQUAL + {2'b00, a[1:0], b[7:4]}, 1'b0);
      put_char(CHAR_EQUAL + {2'b00, b[3:0], c[7:6]}, 1'b0);
      put_char(CHAR_EQUAL + {2'b00, c[5:0]}, 1'b0);
   endtask

   task automatic clear_frame();
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_count    = 2'd0;
      char_sum      = 12'd0;
   endtask

   // Predicts the characters of one request: header, payload, then close.
   task automatic encode_request(input logic start, input logic [4:0] address,
                                 input logic [7:0] command, input logic has_data,
                                 input logic [7:0] payload, input logic close);
      logic [11:0] sum_snapshot;
      staged_valid = 1'b0;
      if (start) begin
         clear_frame();
         frame_open = 1'b1;
         put_char(CHAR_HASH, 1'b0);
         put_char(CHAR_LOWER_A + {3'b000, address}, 1'b0);
         put_char(command, 1'b0);
      end
      // Outside a frame the payload and the close are ignored.
      if (frame_open) begin
         if (has_data) begin
            if (held_count == 2'd2) begin
               put_group(held_bytes[0], held_bytes[1], payload);
               held_count    = 2'd0;
               held_bytes[0] = 8'h00;
               held_bytes[1] = 8'h00;
            end else begin
               held_bytes[held_count[0]] = payload;
               held_count = held_count + 2'd1;
            end
         end
         if (close) begin
            // A short group is padded with zero bytes.
            if (held_count == 2'd1) begin
               put_group(held_bytes[0], 8'h00, 8'h00);
            end else if (held_count == 2'd2) begin
               put_group(held_bytes[0], held_bytes[1], 8'h00);
            end
            sum_snapshot = char_sum;
            put_char(CHAR_EQUAL + {2'b00, sum_snapshot[11:6]}, 1'b0);
            put_char(CHAR_EQUAL + {2'b00, sum_snapshot[5:0]}, 1'b0);
            put_char(CHAR_CR, 1'b1);
            clear_frame();
            frame_open = 1'b0;
         end
      end
      if (staged_valid) begin
         staged_char.end_of_run = 1'b1;
         expected_chars.push_back(staged_char);
      end
   endtask

   // Responses are checked before the request of the same edge is predicted;
   // a request never produces a character on the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         clear_frame();
         frame_open        = 1'b0;
         mismatch_count    = 0;
         chars_outstanding = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               $display("%t: unexpected character: expected none, actual %h", $time,
                        rsp_out_char);
            end else begin
               oldest_char = expected_chars.pop_front();
               if (rsp_out_char !== oldest_char.code) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%t: out_char mismatch: expected %h, actual %h", $time,
                           oldest_char.code, rsp_out_char);
               end
               if (rsp_end_of_frame !== oldest_char.end_of_frame) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%t: end_of_frame mismatch: expected %b, actual %b", $time,
                           oldest_char.end_of_frame, rsp_end_of_frame);
               end
               if (rsp_end_of_run !== oldest_char.end_of_run) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%t: end_of_run mismatch: expected %b, actual %b", $time,
                           oldest_char.end_of_run, rsp_end_of_run);
               end
            end
         end
         if (req_push && !req_full) begin
            encode_request(req_frame_start, req_address, req_command, req_has_data,
                           req_payload_byte, req_frame_end);
         end
         chars_outstanding = expected_chars.size();
      end
   end

endmodule

// File: tb/sv/base64_frame_encoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_frame_encoder_core_test: test top of the frame encoder
// Drives directed frames that cover the header extremes, padding, restarts
// and ignored requests, then a long run of random frames sent in bursts
// while the response side stalls on its own pattern. A checker module
// predicts and compares every character; this top gives the verdict.
// ----------------------------------------------------------------------------
module base64_frame_encoder_core_test;
   import bfe_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RANDOM_REQUESTS = 300;
   localparam int DRAIN_CYCLES    = 16;

   typedef enum int {POP_ALWAYS, POP_COIN, POP_LONG_STALLS} pop_mode_type;

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_push         = 1'b0;
   logic       req_full;
   logic       req_frame_start  = 1'b0;
   logic [4:0] req_address      = 5'd0;
   logic [7:0] req_command      = 8'h00;
   logic       req_has_data     = 1'b0;
   logic [7:0] req_payload_byte = 8'h00;
   logic       req_frame_end    = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop          = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_end_of_frame;
   logic       rsp_end_of_run;
   int         mismatch_count;
   int         chars_outstanding;
   int         burst_left       = 0;

   base64_frame_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_frame_start  (req_frame_start),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_has_data     (req_has_data),
      .req_payload_byte (req_payload_byte),
      .req_frame_end    (req_frame_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_end_of_run   (rsp_end_of_run)
   );

   base64_frame_encoder_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_frame_start   (req_frame_start),
      .req_address       (req_address),
      .req_command       (req_command),
      .req_has_data      (req_has_data),
      .req_payload_byte  (req_payload_byte),
      .req_frame_end     (req_frame_end),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_char      (rsp_out_char),
      .rsp_end_of_frame  (rsp_end_of_frame),
      .rsp_end_of_run    (rsp_end_of_run),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Sends one request and waits until it is accepted. After each burst the
   // push line drops for a random gap.
   task automatic send_request(input logic start, input logic [4:0] address,
                               input logic [7:0] command, input logic has_data,
                               input logic [7:0] payload, input logic close);
      int gap;
      @(negedge clock);
      req_push         <= 1'b1;
      req_frame_start  <= start;
      req_address      <= address;
      req_command      <= command;
      req_has_data     <= has_data;
      req_payload_byte <= payload;
      req_frame_end    <= close;
      do @(posedge clock); while (req_full);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // Now and then a long burst runs without any gap.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left = burst_left - 1;
      end
   endtask

   // The response side switches between steady popping, coin-flip stalls
   // and occasional long stalls.
   initial begin : pop_pattern
      pop_mode_type mode;
      int           mode_left;
      int           stall_left;
      mode       = POP_ALWAYS;
      mode_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = pop_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 80);
         end
         mode_left = mode_left - 1;
         case (mode)
            POP_ALWAYS: begin
               rsp_pop <= 1'b1;
            end
            POP_COIN: begin
               rsp_pop <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (stall_left > 0) begin
                  stall_left = stall_left - 1;
                  rsp_pop <= 1'b0;
               end else begin
                  rsp_pop <= 1'b1;
                  if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
               end
            end
         endcase
      end
   end

   initial begin : stimulus
      int sent;
      int body;
      int i;
      bit abandon;
      bit left_open;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed requests.
      // A request outside any frame is ignored.
      send_request(1'b0, 5'd31, 8'hFF, 1'b1, 8'hFF, 1'b1);
      // Header with the top address and command, closed with no payload.
      send_request(1'b1, 5'd31, 8'hFF, 1'b0, 8'h00, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b0, 8'h00, 1'b1);
      // A full group, then a close that needs no padding.
      send_request(1'b1, 5'd0, 8'h00, 1'b1, 8'hFF, 1'b0);
      send_request(1'b0, 5'd31, 8'hFF, 1'b1, 8'h00, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'hFF, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b0, 8'h00, 1'b1);
      // Two held bytes padded at the close.
      send_request(1'b1, 5'd17, CHAR_CR, 1'b1, 8'hAA, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'h55, 1'b1);
      // Header, one byte and a padded close in a single request.
      send_request(1'b1, 5'd5, 8'h41, 1'b1, 8'h80, 1'b1);
      // A new start drops the open frame and its held bytes.
      send_request(1'b1, 5'd10, 8'h14, 1'b1, 8'h01, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'h02, 1'b0);
      send_request(1'b1, 5'd12, 8'h22, 1'b1, 8'h03, 1'b0);
      // A request with no payload inside a frame.
      send_request(1'b0, 5'd0, 8'h00, 1'b0, 8'h00, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'hC3, 1'b0);
      // The byte that completes a group arrives with the close.
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'h3C, 1'b1);
      // Start and close together with no payload.
      send_request(1'b1, 5'd31, 8'h00, 1'b0, 8'h00, 1'b1);
      send_request(1'b1, 5'd0, 8'hFF, 1'b1, 8'h7F, 1'b0);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'hFE, 1'b1);
      send_request(1'b0, 5'd0, 8'h00, 1'b1, 8'hFF, 1'b1);

      // Random frames: mostly well formed, a few abandoned, with noise
      // between frames. Ignored requests do not count.
      sent      = 0;
      left_open = 1'b0;
      while (sent < RANDOM_REQUESTS) begin
         if (!left_open && $urandom_range(0, 9) == 0) begin
            send_request(1'b0, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end else begin
            body    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(0, 8);
            abandon = ($urandom_range(0, 11) == 0);
            for (i = 0; i <= body; i++) begin
               send_request(i == 0, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 5) != 0, 8'($urandom_range(0, 255)),
                            (i == body) && !abandon);
               sent = sent + 1;
            end
            left_open = abandon;
         end
      end

      // Drain: wait for every predicted character, then let the design idle.
      @(negedge clock);
      req_push <= 1'b0;
      while (chars_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
